// ===== src/rvieu_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rvieu_pkg: shared types and constants of the integer execute unit
// Instruction formats, function codes, status codes, and the item and result
// records that travel between the front end, the queue and the back end.
// ============================================================================
package rvieu_pkg;

    // data path and register file
    localparam int XLEN             = 32;
    localparam int REG_IDX_W        = 5;
    localparam int NUM_REGS_DEFAULT = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
    localparam logic [XLEN-1:0] PC_RESET  = '0;
    localparam logic [XLEN-1:0] SHIFT_MAX = 32'd31;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;

    // instruction format codes as they arrive in tuser
    localparam logic [2:0] OP_REG_ALU = 3'd0;
    localparam logic [2:0] OP_IMM_ALU = 3'd1;
    localparam logic [2:0] OP_JALR    = 3'd2;
    localparam logic [2:0] OP_BRANCH  = 3'd3;
    localparam logic [2:0] OP_LUI     = 3'd4;
    localparam logic [2:0] OP_JAL     = 3'd5;

    // funct7 codes
    localparam logic [6:0] FUNCT7_BASE = 7'b0000000;
    localparam logic [6:0] FUNCT7_ALT  = 7'b0100000;

    // alu funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // result status codes
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN   = 2'd1;
    localparam logic [1:0] STATUS_SHIFT_OOR = 2'd2;

    // instruction class after decode
    typedef enum logic [2:0] {
        KIND_REG_ALU = 3'd0,
        KIND_IMM_ALU = 3'd1,
        KIND_JALR    = 3'd2,
        KIND_BRANCH  = 3'd3,
        KIND_LUI     = 3'd4,
        KIND_JAL     = 3'd5
    } kind_t;

    // classified instruction handed from front end to back end
    typedef struct packed {
        kind_t                 kind;
        logic [2:0]            funct3;
        logic                  alt;        // sub / sra selected
        logic                  dec_err;    // unknown operation
        logic                  reg_shift;  // register shift, amount checked later
        logic [REG_IDX_W-1:0]  dest;
        logic [REG_IDX_W-1:0]  src1;
        logic [REG_IDX_W-1:0]  src2;
        logic [XLEN-1:0]       imm;
    } item_t;

    // result record, first member in the highest bits
    typedef struct packed {
        logic [XLEN-1:0]       written_value;
        logic [REG_IDX_W-1:0]  written_index;
        logic                  wrote_reg;
        logic [XLEN-1:0]       next_pc;
        logic [1:0]            status;
    } result_t;

endpackage

// ===== src/rvieu_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rvieu_front: request intake and classification
// Takes one request per cycle while the queue takes items, unpacks it, flags
// unknown operations and register shifts, and holds the classified item for the queue.
// ============================================================================
module rvieu_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rvieu_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [rvieu_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                item_valid,
    input  logic                                item_ready,
    output rvieu_pkg::item_t                    item
);

    logic              valid_reg;
    logic              valid_next;
    rvieu_pkg::item_t  item_reg;
    rvieu_pkg::item_t  item_next;
    logic              take;

    logic [2:0]  f3;
    logic [6:0]  f7;

    assign f3 = s_tdata[2:0];
    assign f7 = s_tdata[9:3];

    // the stage frees up whenever the queue takes its item
    assign s_tready   = !valid_reg || item_ready;
    assign take       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // classify the incoming request
    always_comb
    begin
        item_next.funct3    = f3;
        item_next.alt       = 1'b0;
        item_next.dec_err   = 1'b0;
        item_next.reg_shift = 1'b0;
        item_next.dest      = s_tdata[14:10];
        item_next.src1      = s_tdata[19:15];
        item_next.src2      = s_tdata[24:20];
        item_next.imm       = s_tdata[56:25];
        item_next.kind      = rvieu_pkg::KIND_LUI;
        unique case (s_tuser)
            rvieu_pkg::OP_REG_ALU:
            begin
                item_next.kind      = rvieu_pkg::KIND_REG_ALU;
                item_next.alt       = (f7 == rvieu_pkg::FUNCT7_ALT);
                item_next.reg_shift = (f3 == rvieu_pkg::F3_SLL) || (f3 == rvieu_pkg::F3_SR);
                item_next.dec_err   = (f7 != rvieu_pkg::FUNCT7_BASE) &&
                                      !((f7 == rvieu_pkg::FUNCT7_ALT) &&
                                        ((f3 == rvieu_pkg::F3_ADD) || (f3 == rvieu_pkg::F3_SR)));
            end
            rvieu_pkg::OP_IMM_ALU:
            begin
                item_next.kind    = rvieu_pkg::KIND_IMM_ALU;
                item_next.dec_err = (f3 == rvieu_pkg::F3_SLL) || (f3 == rvieu_pkg::F3_SR);
            end
            rvieu_pkg::OP_JALR:
            begin
                item_next.kind    = rvieu_pkg::KIND_JALR;
                item_next.dec_err = (f3 != rvieu_pkg::F3_ADD);
            end
            rvieu_pkg::OP_BRANCH:
            begin
                item_next.kind    = rvieu_pkg::KIND_BRANCH;
                item_next.dec_err = (f3 == rvieu_pkg::F3_SLT) || (f3 == rvieu_pkg::F3_SLTU);
            end
            rvieu_pkg::OP_LUI:
            begin
                item_next.kind = rvieu_pkg::KIND_LUI;
            end
            rvieu_pkg::OP_JAL:
            begin
                item_next.kind = rvieu_pkg::KIND_JAL;
            end
            default:
            begin
                item_next.dec_err = 1'b1;
            end
        endcase
    end

    // stage valid
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/rvieu_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rvieu_queue: short item queue between front end and back end
// Two-entry first-in first-out buffer so that either side can stall alone.
// ============================================================================
module rvieu_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  rvieu_pkg::item_t  push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output rvieu_pkg::item_t  pop_item
);

    localparam int PTR_W = $clog2(rvieu_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rvieu_pkg::QUEUE_DEPTH + 1);

    rvieu_pkg::item_t  slot_reg [rvieu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(rvieu_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(rvieu_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(rvieu_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/rvieu_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rvieu_back: register read, execute and result stage
// Reads both source registers from the register file memory, then executes
// the instruction, writes back, updates the pc and registers the result.
// ============================================================================
module rvieu_back
#(
    parameter int NUM_REGS = rvieu_pkg::NUM_REGS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rvieu_pkg::item_t    item,
    output logic                res_valid,
    input  logic                res_ready,
    output rvieu_pkg::result_t  res
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int XLEN  = rvieu_pkg::XLEN;
    localparam int RW    = rvieu_pkg::REG_IDX_W;

    // register file memory with per-entry valid bits
    logic [XLEN-1:0]      rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0]  rf_valid_reg;

    // read stage
    logic                 rd_valid_reg;
    logic                 rd_valid_next;
    rvieu_pkg::item_t     rd_item_reg;
    logic [XLEN-1:0]      a_reg;
    logic [XLEN-1:0]      b_reg;
    logic                 rd_load;

    // result stage
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rvieu_pkg::result_t   out_reg;
    rvieu_pkg::result_t   out_next;
    logic                 out_free;
    logic                 exec_go;

    // program counter
    logic [XLEN-1:0]      pc_reg;

    // write port
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [XLEN-1:0]      wr_val;

    // read port decode
    logic                 src1_ok;
    logic                 src2_ok;
    logic [IDX_W-1:0]     src1_idx;
    logic [IDX_W-1:0]     src2_idx;

    // execute
    logic [XLEN-1:0]      opb;
    logic [XLEN-1:0]      alu_res;
    logic [XLEN-1:0]      pc_plus4;
    logic [XLEN-1:0]      pc_target;
    logic                 lt_s;
    logic                 lt_u;
    logic                 taken;
    logic [1:0]           status;
    logic                 wr_ok;
    logic                 dest_ok;

    // pipeline flow
    assign out_free   = !out_valid_reg || res_ready;
    assign exec_go    = rd_valid_reg && out_free;
    assign item_ready = !rd_valid_reg || exec_go;
    assign rd_load    = item_valid && item_ready;
    assign res_valid  = out_valid_reg;
    assign res        = out_reg;

    // source index decode, register 0 and missing registers read zero
    assign src1_ok  = (item.src1 != '0) && ({1'b0, item.src1} < (RW+1)'(NUM_REGS));
    assign src2_ok  = (item.src2 != '0) && ({1'b0, item.src2} < (RW+1)'(NUM_REGS));
    assign src1_idx = item.src1[IDX_W-1:0];
    assign src2_idx = item.src2[IDX_W-1:0];
    assign dest_ok  = (rd_item_reg.dest != '0) &&
                      ({1'b0, rd_item_reg.dest} < (RW+1)'(NUM_REGS));

    // operands and comparisons
    assign opb       = (rd_item_reg.kind == rvieu_pkg::KIND_IMM_ALU) ? rd_item_reg.imm : b_reg;
    assign lt_s      = $signed(a_reg) < $signed(opb);
    assign lt_u      = a_reg < opb;
    assign pc_plus4  = pc_reg + rvieu_pkg::PC_STEP;
    assign pc_target = pc_reg + rd_item_reg.imm;

    // alu
    always_comb
    begin
        unique case (rd_item_reg.funct3)
            rvieu_pkg::F3_ADD:  alu_res = rd_item_reg.alt ? a_reg - opb : a_reg + opb;
            rvieu_pkg::F3_SLL:  alu_res = a_reg << opb[4:0];
            rvieu_pkg::F3_SLT:  alu_res = {{(XLEN-1){1'b0}}, lt_s};
            rvieu_pkg::F3_SLTU: alu_res = {{(XLEN-1){1'b0}}, lt_u};
            rvieu_pkg::F3_XOR:  alu_res = a_reg ^ opb;
            rvieu_pkg::F3_SR:   alu_res = rd_item_reg.alt ?
                                          XLEN'($signed(a_reg) >>> opb[4:0]) :
                                          a_reg >> opb[4:0];
            rvieu_pkg::F3_OR:   alu_res = a_reg | opb;
            rvieu_pkg::F3_AND:  alu_res = a_reg & opb;
        endcase
    end

    // branch condition
    always_comb
    begin
        unique case (rd_item_reg.funct3)
            rvieu_pkg::F3_BEQ:  taken = (a_reg == b_reg);
            rvieu_pkg::F3_BNE:  taken = (a_reg != b_reg);
            rvieu_pkg::F3_BLT:  taken = lt_s;
            rvieu_pkg::F3_BGE:  taken = !lt_s;
            rvieu_pkg::F3_BLTU: taken = lt_u;
            rvieu_pkg::F3_BGEU: taken = !lt_u;
            default:            taken = 1'b0;
        endcase
    end

    // status of the executing instruction
    always_comb
    begin
        priority if (rd_item_reg.dec_err)
        begin
            status = rvieu_pkg::STATUS_UNKNOWN;
        end
        else if (rd_item_reg.reg_shift && (b_reg > rvieu_pkg::SHIFT_MAX))
        begin
            status = rvieu_pkg::STATUS_SHIFT_OOR;
        end
        else
        begin
            status = rvieu_pkg::STATUS_DONE;
        end
    end

    // result, next pc and write-back
    always_comb
    begin
        out_next.status  = status;
        out_next.next_pc = pc_plus4;
        wr_val           = alu_res;
        wr_ok            = 1'b1;
        unique case (rd_item_reg.kind)
            rvieu_pkg::KIND_REG_ALU,
            rvieu_pkg::KIND_IMM_ALU:
            begin
                wr_val = alu_res;
            end
            rvieu_pkg::KIND_JALR:
            begin
                wr_val           = pc_plus4;
                out_next.next_pc = (a_reg + rd_item_reg.imm) & ~XLEN'(1);
            end
            rvieu_pkg::KIND_BRANCH:
            begin
                wr_ok = 1'b0;
                if (taken)
                begin
                    out_next.next_pc = pc_target;
                end
            end
            rvieu_pkg::KIND_LUI:
            begin
                wr_val = rd_item_reg.imm;
            end
            rvieu_pkg::KIND_JAL:
            begin
                wr_val           = pc_plus4;
                out_next.next_pc = pc_target;
            end
            default:
            begin
                wr_ok = 1'b0;
            end
        endcase
        if (status != rvieu_pkg::STATUS_DONE)
        begin
            out_next.next_pc = pc_reg;
            wr_ok            = 1'b0;
        end
        wr_en                  = exec_go && wr_ok && dest_ok;
        out_next.wrote_reg     = wr_ok && dest_ok;
        out_next.written_index = (wr_ok && dest_ok) ? rd_item_reg.dest : '0;
        out_next.written_value = (wr_ok && dest_ok) ? wr_val : '0;
    end

    assign wr_idx = rd_item_reg.dest[IDX_W-1:0];

    // register file storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_idx] <= wr_val;
        end
    end

    // registered reads, bypassing the write of the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_load)
        begin
            rd_item_reg <= item;
            if (!src1_ok)
            begin
                a_reg <= '0;
            end
            else if (wr_en && (wr_idx == src1_idx))
            begin
                a_reg <= wr_val;
            end
            else
            begin
                a_reg <= rf_valid_reg[src1_idx] ? rf_mem[src1_idx] : '0;
            end
            if (!src2_ok)
            begin
                b_reg <= '0;
            end
            else if (wr_en && (wr_idx == src2_idx))
            begin
                b_reg <= wr_val;
            end
            else
            begin
                b_reg <= rf_valid_reg[src2_idx] ? rf_mem[src2_idx] : '0;
            end
        end
    end

    // stage valids
    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (rd_load)
        begin
            rd_valid_next = 1'b1;
        end
        else if (exec_go)
        begin
            rd_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state, pc and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= rvieu_pkg::PC_RESET;
            rf_valid_reg  <= '0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (exec_go)
            begin
                pc_reg <= out_next.next_pc;
            end
            if (wr_en)
            begin
                rf_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== src/rv32i_integer_execute_unit_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rv32i_integer_execute_unit_top: RV32I integer execute unit
// Executes decoded register/immediate ALU, branch, jal, jalr and lui
// instructions against a register file and program counter.
// ============================================================================
//
// channel   dir  signals                       content
// s         in   s_tvalid s_tready s_tdata     decoded instruction request
//                s_tuser                       instruction format
// m         out  m_tvalid m_tready m_tdata     execution result
//
// One instruction per cycle sustained while the result side accepts; a request
// passes the intake register, the queue, the register read and the result stage.
// The pc and register file update in the execute cycle, so dependent
// instructions follow back to back through the write-to-read bypass.
// Reset clears the pc and marks all registers as zero; no clearing pass.
// A stalled result side fills the result, read stage, queue and intake.
//
module rv32i_integer_execute_unit_top
#(
    parameter int NUM_REGS = rvieu_pkg::NUM_REGS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // funct3[2:0] funct7[9:3] dest_reg[14:10] src1_reg[19:15] src2_reg[24:20]
    // immediate[56:25], zero fill [63:57]
    input  logic [rvieu_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[2:0]
    input  logic [rvieu_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0] next_pc[33:2] wrote_reg[34] written_index[39:35]
    // written_value[71:40]
    output logic [$bits(rvieu_pkg::result_t)-1:0] m_tdata
);

    logic                fq_valid;
    logic                fq_ready;
    rvieu_pkg::item_t    fq_item;
    logic                qb_valid;
    logic                qb_ready;
    rvieu_pkg::item_t    qb_item;
    rvieu_pkg::result_t  res;

    // request intake and classification
    rvieu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    // decoupling queue
    rvieu_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // register read and execute
    rvieu_back #(.NUM_REGS(NUM_REGS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = res;

`ifndef SYNTH
    // a register write only comes with a successful instruction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.wrote_reg |-> res.status == rvieu_pkg::STATUS_DONE)
    else $error("register write reported on a failed instruction");

    // register 0 is never reported as written
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.wrote_reg |-> res.written_index != '0)
    else $error("write to register 0 reported");

    // no write means zero index and value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.wrote_reg |-> res.written_index == '0 && res.written_value == '0)
    else $error("write fields not cleared without a write");

    // status stays within its defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.status == rvieu_pkg::STATUS_DONE ||
                     res.status == rvieu_pkg::STATUS_UNKNOWN ||
                     res.status == rvieu_pkg::STATUS_SHIFT_OOR)
    else $error("undefined status code");
`endif

endmodule

// ===== verif/rv32i_integer_execute_unit_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rv32i_integer_execute_unit_top_tb: testbench of the RV32I integer execute unit
// Sends decoded instructions over the request stream and predicts every result
// with a local copy of the register file and pc. Each result is compared field
// by field, in order. Directed tests come first, then random instruction
// mixes with idle cycles on both sides, and a long result-side stall.
// ============================================================================
module rv32i_integer_execute_unit_top_tb;

    import rvieu_pkg::*;

    localparam int NUM_REGS = NUM_REGS_DEFAULT;

    // format codes the block does not know, and the jalr funct3 code
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic [2:0] F3_JALR     = 3'd0;

    localparam int RANDOM_ITEMS = 900;
    localparam int BURST_ITEMS  = 40;
    localparam int HOLD_ITEMS   = 16;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_LIMIT  = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [$bits(result_t)-1:0] m_tdata;

    // architectural state as the block should see it
    logic [XLEN-1:0] arch_regs [0:NUM_REGS-1];
    logic [XLEN-1:0] arch_pc;

    result_t expected_results[$];

    // shared control between the test sequence and the result side
    bit no_idle = 1'b0;
    int hold_off_len = 0;

    int fail_count = 0;
    int results_checked = 0;
    int error_results = 0;
    int register_writes = 0;
    int requests_per_op [0:7];

    rv32i_integer_execute_unit_top #(
        .NUM_REGS(NUM_REGS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // register read, x0 and indexes past the file read as zero
    function automatic logic [XLEN-1:0] read_arch_reg(input logic [REG_IDX_W-1:0] idx);
        if (idx == 0 || idx >= NUM_REGS)
            return '0;
        return arch_regs[idx];
    endfunction

    // alu result with a legal flag in the top bit
    function automatic logic [XLEN:0] alu_eval(input logic [2:0] f3, input logic [6:0] f7,
                                               input logic is_reg, input logic [XLEN-1:0] a,
                                               input logic [XLEN-1:0] b);
        logic alt;
        logic [4:0] sh;
        logic [XLEN-1:0] val;
        alt = is_reg && (f7 == FUNCT7_ALT);
        sh = b[4:0];
        val = '0;
        if (is_reg && f7 != FUNCT7_BASE && !(alt && (f3 == F3_ADD || f3 == F3_SR)))
            return '0;
        case (f3)
            F3_ADD:  val = alt ? a - b : a + b;
            F3_SLL:
            begin
                if (!is_reg)
                    return '0;
                val = a << sh;
            end
            F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  val = a ^ b;
            F3_SR:
            begin
                if (!is_reg)
                    return '0;
                if (alt)
                    val = $signed(a) >>> sh;
                else
                    val = a >> sh;
            end
            F3_OR:   val = a | b;
            default: val = a & b;
        endcase
        return {1'b1, val};
    endfunction

    // executes one instruction on the local state and builds its result
    task automatic execute_instruction(input logic [2:0] op, input logic [2:0] f3,
                                       input logic [6:0] f7, input logic [REG_IDX_W-1:0] rd,
                                       input logic [REG_IDX_W-1:0] rs1,
                                       input logic [REG_IDX_W-1:0] rs2,
                                       input logic [XLEN-1:0] imm, output result_t res);
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] npc;
        logic [XLEN-1:0] val;
        logic [XLEN:0] alu;
        logic wr;
        logic taken;
        logic [1:0] st;
        a = read_arch_reg(rs1);
        b = read_arch_reg(rs2);
        pc = arch_pc;
        npc = pc + PC_STEP;
        val = '0;
        wr = 1'b0;
        taken = 1'b0;
        st = STATUS_DONE;
        case (op)
            OP_REG_ALU:
            begin
                alu = alu_eval(f3, f7, 1'b1, a, b);
                if (!alu[XLEN])
                    st = STATUS_UNKNOWN;
                else if ((f3 == F3_SLL || f3 == F3_SR) && b > SHIFT_MAX)
                    st = STATUS_SHIFT_OOR;
                else
                begin
                    wr = 1'b1;
                    val = alu[XLEN-1:0];
                end
            end
            OP_IMM_ALU:
            begin
                alu = alu_eval(f3, FUNCT7_BASE, 1'b0, a, imm);
                if (!alu[XLEN])
                    st = STATUS_UNKNOWN;
                else
                begin
                    wr = 1'b1;
                    val = alu[XLEN-1:0];
                end
            end
            OP_JALR:
            begin
                if (f3 != F3_JALR)
                    st = STATUS_UNKNOWN;
                else
                begin
                    val = pc + PC_STEP;
                    wr = 1'b1;
                    npc = (a + imm) & ~32'd1;
                end
            end
            OP_BRANCH:
            begin
                case (f3)
                    F3_BEQ:  taken = (a == b);
                    F3_BNE:  taken = (a != b);
                    F3_BLT:  taken = ($signed(a) < $signed(b));
                    F3_BGE:  taken = !($signed(a) < $signed(b));
                    F3_BLTU: taken = (a < b);
                    F3_BGEU: taken = (a >= b);
                    default: st = STATUS_UNKNOWN;
                endcase
                if (taken)
                    npc = pc + imm;
            end
            OP_LUI:
            begin
                val = imm;
                wr = 1'b1;
            end
            OP_JAL:
            begin
                val = pc + PC_STEP;
                wr = 1'b1;
                npc = pc + imm;
            end
            default: st = STATUS_UNKNOWN;
        endcase

        // errors leave the state untouched
        if (st != STATUS_DONE)
        begin
            npc = pc;
            wr = 1'b0;
        end
        if (rd == 0 || rd >= NUM_REGS)
            wr = 1'b0;
        if (wr)
            arch_regs[rd] = val;
        arch_pc = npc;

        res.status = st;
        res.next_pc = npc;
        res.wrote_reg = wr;
        res.written_index = wr ? rd : '0;
        res.written_value = wr ? val : '0;
    endtask

    // offers one request, waits for acceptance and records its result
    task automatic send_request(input logic [2:0] op, input logic [2:0] f3,
                                input logic [6:0] f7, input logic [REG_IDX_W-1:0] rd,
                                input logic [REG_IDX_W-1:0] rs1,
                                input logic [REG_IDX_W-1:0] rs2, input logic [XLEN-1:0] imm);
        int gap;
        logic ready;
        result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'b0, imm, rs2, rs1, rd, f7, f3};
        // inputs only move at rising edges, so the falling edge shows the handshake
        do
        begin
            @(negedge clk);
            ready = s_tready;
            @(posedge clk);
        end
        while (!ready);
        execute_instruction(op, f3, f7, rd, rs1, rs2, imm, predicted);
        expected_results.push_back(predicted);
        requests_per_op[op]++;
    endtask

    // operand values weighted toward small shift amounts and extremes
    function automatic logic [XLEN-1:0] random_operand();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom_range(0, 31);
        if (pick < 6)
            return 32'd0 - $urandom_range(1, 16);
        if (pick == 6)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0;
            endcase
        end
        return $urandom();
    endfunction

    // mostly well-formed instructions with random content, some noise
    task automatic send_random_request();
        int pick;
        logic [2:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [REG_IDX_W-1:0] rd;
        logic [REG_IDX_W-1:0] rs1;
        logic [REG_IDX_W-1:0] rs2;
        logic [XLEN-1:0] imm;
        pick = $urandom_range(0, 99);
        f3 = $urandom_range(0, 7);
        f7 = $urandom_range(0, 127);
        rd = $urandom_range(0, 31);
        rs1 = $urandom_range(0, 31);
        rs2 = $urandom_range(0, 31);
        imm = random_operand();
        if (pick < 30)
        begin
            op = OP_REG_ALU;
            if ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(0, 1))
                f7 = FUNCT7_ALT;
            else
                f7 = FUNCT7_BASE;
        end
        else if (pick < 52)
        begin
            // immediate form has no shifts, fold them onto add / xor
            op = OP_IMM_ALU;
            if (f3 == F3_SLL || f3 == F3_SR)
                f3 = f3 ^ 3'd1;
        end
        else if (pick < 67)
        begin
            op = OP_BRANCH;
            if (f3 == 3'd2 || f3 == 3'd3)
                f3 = f3 | 3'd4;
        end
        else if (pick < 75)
            op = OP_LUI;
        else if (pick < 80)
            op = OP_JAL;
        else if (pick < 85)
        begin
            op = OP_JALR;
            f3 = F3_JALR;
        end
        else
            op = $urandom_range(0, 7);
        send_request(op, f3, f7, rd, rs1, rs2, imm);
    endtask

    // alu operations on extreme operands
    task automatic test_alu_directed();
        // x1 = min int, x2 = max int, x31 = all ones, x4 = 31
        send_request(OP_LUI, 3'd7, 7'h7f, 5'd1, 5'd31, 5'd31, 32'h8000_0000);
        send_request(OP_LUI, 3'd0, 7'h00, 5'd2, 5'd0, 5'd0, 32'h7fff_ffff);
        send_request(OP_IMM_ALU, F3_XOR, 7'h7f, 5'd31, 5'd0, 5'd0, 32'hffff_ffff);
        send_request(OP_IMM_ALU, F3_OR, FUNCT7_BASE, 5'd4, 5'd0, 5'd0, 32'd31);
        send_request(OP_REG_ALU, F3_ADD, FUNCT7_BASE, 5'd5, 5'd1, 5'd2, '0);
        send_request(OP_REG_ALU, F3_ADD, FUNCT7_ALT, 5'd6, 5'd1, 5'd2, '0);
        send_request(OP_REG_ALU, F3_SLL, FUNCT7_BASE, 5'd7, 5'd2, 5'd4, '0);
        send_request(OP_REG_ALU, F3_SR, FUNCT7_BASE, 5'd8, 5'd1, 5'd4, '0);
        send_request(OP_REG_ALU, F3_SR, FUNCT7_ALT, 5'd9, 5'd1, 5'd4, '0);
        send_request(OP_REG_ALU, F3_SLT, FUNCT7_BASE, 5'd10, 5'd1, 5'd2, '0);
        send_request(OP_REG_ALU, F3_SLTU, FUNCT7_BASE, 5'd11, 5'd1, 5'd2, '0);
        send_request(OP_REG_ALU, F3_XOR, FUNCT7_BASE, 5'd12, 5'd1, 5'd31, '0);
        send_request(OP_REG_ALU, F3_OR, FUNCT7_BASE, 5'd13, 5'd1, 5'd2, '0);
        send_request(OP_REG_ALU, F3_AND, FUNCT7_BASE, 5'd14, 5'd31, 5'd2, '0);
        send_request(OP_IMM_ALU, F3_SLT, FUNCT7_BASE, 5'd15, 5'd1, 5'd0, 32'hffff_ffff);
        send_request(OP_IMM_ALU, F3_SLTU, FUNCT7_BASE, 5'd16, 5'd2, 5'd0, 32'hffff_ffff);
        send_request(OP_IMM_ALU, F3_AND, FUNCT7_BASE, 5'd17, 5'd31, 5'd0, 32'h0000_0f0f);
        // write to x0 is dropped but the pc moves on
        send_request(OP_IMM_ALU, F3_ADD, FUNCT7_BASE, 5'd0, 5'd2, 5'd0, 32'd1);
    endtask

    // every branch condition and both jumps
    task automatic test_control_directed();
        send_request(OP_BRANCH, F3_BEQ, FUNCT7_BASE, 5'd0, 5'd1, 5'd1, 32'd16);
        send_request(OP_BRANCH, F3_BNE, FUNCT7_BASE, 5'd0, 5'd1, 5'd1, 32'hffff_fff8);
        send_request(OP_BRANCH, F3_BLT, FUNCT7_BASE, 5'd0, 5'd1, 5'd2, 32'h0000_0100);
        send_request(OP_BRANCH, F3_BGE, FUNCT7_BASE, 5'd0, 5'd1, 5'd2, 32'd64);
        send_request(OP_BRANCH, F3_BLTU, FUNCT7_BASE, 5'd0, 5'd2, 5'd1, 32'hffff_ffec);
        send_request(OP_BRANCH, F3_BGEU, FUNCT7_BASE, 5'd0, 5'd31, 5'd1, 32'd12);
        send_request(OP_JAL, 3'd5, 7'h33, 5'd20, 5'd0, 5'd0, 32'hffff_fffc);
        // odd target, bit 0 is cleared
        send_request(OP_JALR, F3_JALR, 7'h7f, 5'd21, 5'd4, 5'd0, 32'd64);
    endtask

    // unknown codes and out-of-range shift amounts
    task automatic test_error_cases();
        // bad funct7 wins over a bad shift amount
        send_request(OP_REG_ALU, F3_SLL, 7'h7f, 5'd3, 5'd2, 5'd31, '0);
        send_request(OP_REG_ALU, F3_XOR, FUNCT7_ALT, 5'd3, 5'd1, 5'd2, '0);
        send_request(OP_IMM_ALU, F3_SLL, FUNCT7_BASE, 5'd3, 5'd1, 5'd0, 32'd1);
        send_request(OP_IMM_ALU, F3_SR, FUNCT7_BASE, 5'd3, 5'd1, 5'd0, 32'd1);
        send_request(OP_BRANCH, 3'd2, FUNCT7_BASE, 5'd0, 5'd1, 5'd1, 32'd8);
        send_request(OP_JALR, 3'd7, FUNCT7_BASE, 5'd3, 5'd4, 5'd0, 32'd8);
        send_request(OP_UNUSED_6, F3_ADD, FUNCT7_BASE, 5'd3, 5'd1, 5'd2, 32'd4);
        send_request(OP_UNUSED_7, F3_ADD, FUNCT7_BASE, 5'd3, 5'd1, 5'd2, 32'd4);
        // shift amount negative, then large positive
        send_request(OP_REG_ALU, F3_SLL, FUNCT7_BASE, 5'd3, 5'd2, 5'd31, '0);
        send_request(OP_REG_ALU, F3_SR, FUNCT7_ALT, 5'd3, 5'd1, 5'd2, '0);
    endtask

    // random instruction mix, idle cycles switched off for every third stretch
    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = ((i / 150) % 3) == 2;
            send_random_request();
        end
        no_idle = 1'b0;
    endtask

    // back-to-back requests with the result side always ready
    task automatic test_burst_no_idle();
        no_idle = 1'b1;
        repeat (BURST_ITEMS) send_random_request();
        no_idle = 1'b0;
    endtask

    // result side holds off while requests keep coming, input must stall
    task automatic test_backpressure();
        hold_off_len = HOLD_CYCLES;
        no_idle = 1'b1;
        repeat (HOLD_ITEMS) send_random_request();
        no_idle = 1'b0;
    endtask

    // result side: random stalls per result, long hold-off on request
    initial
    begin : result_sink
        int stall;
        int hold;
        logic took;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_len > 0)
            begin
                hold = hold_off_len;
                hold_off_len = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = m_tvalid;
                @(posedge clk);
            end
            while (!took && hold_off_len == 0);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(negedge clk)
    begin : result_checker
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d next_pc %h", got.status, got.next_pc);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.status != STATUS_DONE)
                    error_results++;
                if (want.wrote_reg)
                    register_writes++;
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.next_pc !== want.next_pc)
                begin
                    $error("next_pc: expected %h, got %h", want.next_pc, got.next_pc);
                    fail_count++;
                end
                if (got.wrote_reg !== want.wrote_reg)
                begin
                    $error("wrote_reg: expected %0d, got %0d", want.wrote_reg, got.wrote_reg);
                    fail_count++;
                end
                if (got.written_index !== want.written_index)
                begin
                    $error("written_index: expected %0d, got %0d",
                           want.written_index, got.written_index);
                    fail_count++;
                end
                if (got.written_value !== want.written_value)
                begin
                    $error("written_value: expected %h, got %h",
                           want.written_value, got.written_value);
                    fail_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin : test_sequence
        int wait_cycles;
        for (int i = 0; i < NUM_REGS; i++)
            arch_regs[i] = '0;
        for (int i = 0; i < 8; i++)
            requests_per_op[i] = 0;
        arch_pc = PC_RESET;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alu_directed();
        test_control_directed();
        test_error_cases();
        test_random_mix();
        test_burst_no_idle();
        test_backpressure();
        s_tvalid <= 1'b0;

        // drain outstanding results
        wait_cycles = 0;
        while (expected_results.size() > 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (expected_results.size() > 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count += expected_results.size();
        end
        repeat (16) @(posedge clk);

        $display("ran %0d reg alu, %0d imm alu, %0d branch, %0d jal, %0d jalr, %0d lui, %0d bad op",
                 requests_per_op[OP_REG_ALU], requests_per_op[OP_IMM_ALU],
                 requests_per_op[OP_BRANCH], requests_per_op[OP_JAL], requests_per_op[OP_JALR],
                 requests_per_op[OP_LUI],
                 requests_per_op[OP_UNUSED_6] + requests_per_op[OP_UNUSED_7]);
        $display("checked %0d results: %0d with error status, %0d register writes",
                 results_checked, error_results, register_writes);
        if (fail_count == 0)
            $display("rv32i_integer_execute_unit_top_tb: PASS");
        else
            $display("rv32i_integer_execute_unit_top_tb: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin : run_limit
        #2_000_000;
        $display("rv32i_integer_execute_unit_top_tb: FAIL");
        $finish;
    end

endmodule
